// ===== rtl/core/tank_drive_command_mixer_defines.svh =====
// assertion helpers used by the mixer sequencer
`ifndef TANK_DRIVE_COMMAND_MIXER_DEFINES_SVH
`define TANK_DRIVE_COMMAND_MIXER_DEFINES_SVH

// same-cycle implication
`define TDCM_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TDCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/tdcm_pkg.sv =====
package tdcm_pkg;

	// fixed point of the speed levels
	localparam int FRAC_BITS = 8;
	localparam int LW        = 8 + FRAC_BITS;

	// shared divider sizing
	localparam int NW    = 23 + FRAC_BITS;
	localparam int NW2   = NW + (NW % 2);
	localparam int DW    = (7 + FRAC_BITS > 16) ? 7 + FRAC_BITS : 16;
	localparam int STEPS = NW2 / 2;
	localparam int CW    = $clog2(STEPS + 1);

	// mixer constants
	localparam int DEADZONE   = 15;
	localparam int LIFT_MIN   = 500;
	localparam int LIFT_GAIN  = 3;
	localparam int HEAD_WRAP  = 360;
	localparam int HEAD_HALF  = 180;
	localparam int TURN_CLAMP = 127;
	localparam int PULSE_TURN = 30;
	localparam int PULSE_HOLD = 16;
	localparam int PULSE_WRAP = 17;
	localparam int FWD_MIN    = 40;
	localparam int NEAR_DIST  = 16;
	localparam int MV_SCALE   = 12000;
	localparam int MV_LIMIT   = 24000;
	localparam int MV_DIV     = 127 * (1 << FRAC_BITS);

	// drive modes
	localparam logic [1:0] MODE_USER     = 2'd0;
	localparam logic [1:0] MODE_DISTANCE = 2'd2;

	// register indexes
	typedef enum logic [2:0] {
		REG_DRIVE_MODE   = 3'd0,
		REG_FACE_HEADING = 3'd1,
		REG_AUTO_SPEED   = 3'd2,
		REG_TARGET_POS   = 3'd3,
		REG_LIFT_TOP     = 3'd4
	} reg_idx_t;

	// division jobs
	typedef enum logic [1:0] {
		OP_FWD   = 2'd0,
		OP_TURN  = 2'd1,
		OP_RIGHT = 2'd2,
		OP_LEFT  = 2'd3
	} div_op_t;

	typedef struct packed {
		logic    capture;
		logic    div_start;
		div_op_t op;
		logic    filt_write;
		logic    apply;
		logic    right_write;
		logic    out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

endpackage

// ===== rtl/core/tank_drive_command_mixer.sv =====
// each request makes four passes through one shared divider (two quotient bits
//   per cycle): forward and turn filter steps, then right and left millivolts;
//   new requests stall until the previous result is loaded to the output register
// a finished result waits in the output register while the next request runs
// reset (arst_n low): levels, pulse count and cancel flag clear, drive mode user,
//   lift top 4095, other configuration registers zero
module tank_drive_command_mixer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_write,
	input  logic [2:0]          cfg_index,
	input  logic [20:0]         cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic signed [7:0]   stick_forward,
	input  logic signed [7:0]   stick_turn,
	input  logic [11:0]         lift_height,
	input  logic [8:0]          heading_now,
	input  logic signed [20:0]  wheel_position,
	input  logic                cancel_button,
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [15:0]  right_millivolts,
	output logic signed [15:0]  left_millivolts
);
	import tdcm_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer
	tdcm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.status    (status),
		.cmd       (cmd)
	);

	// arithmetic and state
	tdcm_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write        (cfg_write),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.stick_forward    (stick_forward),
		.stick_turn       (stick_turn),
		.lift_height      (lift_height),
		.heading_now      (heading_now),
		.wheel_position   (wheel_position),
		.cancel_button    (cancel_button),
		.cmd              (cmd),
		.status           (status),
		.right_millivolts (right_millivolts),
		.left_millivolts  (left_millivolts)
	);

endmodule

// ===== rtl/core/tdcm_div.sv =====
module tdcm_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tdcm_pkg::NW2-1:0]   num,
	input  logic [tdcm_pkg::DW-1:0]    den,
	output logic [tdcm_pkg::NW2-1:0]   quo,
	output logic                       done
);
	import tdcm_pkg::*;

	logic [CW-1:0]  cnt_q;
	logic           done_q;
	logic [DW-1:0]  rem_q;
	logic [DW-1:0]  den_q;
	logic [NW2-1:0] nq_q;
	logic           busy;
	logic [DW:0]    r1a;
	logic [DW:0]    r1;
	logic [DW:0]    r2a;
	logic [DW:0]    r2;
	logic           q1;
	logic           q2;

	assign busy = (cnt_q != '0);

	// two restoring steps per cycle
	always_comb begin
		r1a = {rem_q, nq_q[NW2-1]};
		q1  = (r1a >= {1'b0, den_q});
		r1  = q1 ? (r1a - {1'b0, den_q}) : r1a;
		r2a = {r1[DW-1:0], nq_q[NW2-2]};
		q2  = (r2a >= {1'b0, den_q});
		r2  = q2 ? (r2a - {1'b0, den_q}) : r2a;
	end

	// step counter and done pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy && (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(STEPS);
			end else if (busy) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	// partial remainder and quotient shifter
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			nq_q  <= num;
			den_q <= den;
		end else if (busy) begin
			rem_q <= r2[DW-1:0];
			nq_q  <= {nq_q[NW2-3:0], q1, q2};
		end
	end

	assign quo  = nq_q;
	assign done = done_q;

endmodule

// ===== rtl/core/tdcm_ctrl.sv =====
`include "tank_drive_command_mixer_defines.svh"

module tdcm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              out_stall,
	output logic              out_valid,
	input  tdcm_pkg::status_t status,
	output tdcm_pkg::cmd_t    cmd
);
	import tdcm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_GO,
		S_WAIT,
		S_APPLY,
		S_LOAD
	} state_t;

	state_t  state_q;
	div_op_t op_q;
	logic    out_valid_q;
	logic    accept;
	logic    load_ok;

	assign accept   = (state_q == S_IDLE) && in_valid;
	assign load_ok  = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_valid = out_valid_q;

	// command decode
	always_comb begin
		cmd             = '0;
		cmd.op          = op_q;
		cmd.capture     = accept;
		cmd.div_start   = (state_q == S_GO);
		cmd.apply       = (state_q == S_APPLY);
		cmd.out_load    = (state_q == S_LOAD) && load_ok;
		cmd.filt_write  = (state_q == S_WAIT) && status.div_done &&
			(op_q == OP_FWD || op_q == OP_TURN);
		cmd.right_write = (state_q == S_WAIT) && status.div_done && (op_q == OP_RIGHT);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_FWD;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q    <= OP_FWD;
						state_q <= S_GO;
					end
				end
				S_GO: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (status.div_done) begin
						unique case (op_q)
							OP_FWD: begin
								op_q    <= OP_TURN;
								state_q <= S_GO;
							end
							OP_TURN: begin
								state_q <= S_APPLY;
							end
							OP_RIGHT: begin
								op_q    <= OP_LEFT;
								state_q <= S_GO;
							end
							OP_LEFT: begin
								state_q <= S_LOAD;
							end
						endcase
					end
				end
				S_APPLY: begin
					op_q    <= OP_RIGHT;
					state_q <= S_GO;
				end
				S_LOAD: begin
					if (load_ok) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// checks
	`TDCM_ASSERT_NEXT(a_accept_starts, accept, state_q == S_GO, "accept did not start division")
	`TDCM_ASSERT_NOW(a_done_in_wait, status.div_done, state_q == S_WAIT, "divider done outside wait")
	`TDCM_ASSERT_NEXT(a_load_shows, cmd.out_load, out_valid_q && state_q == S_IDLE, "load lost")

endmodule

// ===== rtl/core/tdcm_dp.sv =====
module tdcm_dp (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_write,
	input  logic [2:0]           cfg_index,
	input  logic [20:0]          cfg_data,
	input  logic signed [7:0]    stick_forward,
	input  logic signed [7:0]    stick_turn,
	input  logic [11:0]          lift_height,
	input  logic [8:0]           heading_now,
	input  logic signed [20:0]   wheel_position,
	input  logic                 cancel_button,
	input  tdcm_pkg::cmd_t       cmd,
	output tdcm_pkg::status_t    status,
	output logic signed [15:0]   right_millivolts,
	output logic signed [15:0]   left_millivolts
);
	import tdcm_pkg::*;

	// configuration
	logic [1:0]          mode_q;
	logic [8:0]          face_q;
	logic signed [7:0]   spd_q;
	logic signed [20:0]  target_q;
	logic [11:0]         top_q;

	// mixer state
	logic signed [LW-1:0] fwd_q;
	logic signed [LW-1:0] turn_q;
	logic [4:0]           pulse_q;
	logic                 cancelled_q;

	// captured request
	logic signed [7:0]   sf_q;
	logic signed [7:0]   st_q;
	logic [11:0]         lift_q;
	logic [8:0]          head_q;
	logic signed [20:0]  wheel_q;
	logic                cancel_q;

	// division context
	logic                 sign_q;
	logic signed [15:0]   right_tmp_q;
	logic signed [15:0]   right_mv_q;
	logic signed [15:0]   left_mv_q;

	logic [NW2-1:0] quo;
	logic           div_done;

	// user targets
	logic signed [7:0]    sf_dz;
	logic signed [7:0]    st_dz;
	logic                 lift_low;
	logic signed [LW-1:0] fq_full;
	logic signed [LW-1:0] tq_full;
	logic signed [LW-1:0] fq;
	logic signed [LW-1:0] tq;

	always_comb begin
		sf_dz    = (sf_q > -8'sd15 && sf_q < 8'sd15) ? 8'sd0 : sf_q;
		st_dz    = (st_q > -8'sd15 && st_q < 8'sd15) ? 8'sd0 : st_q;
		fq_full  = LW'(sf_dz) <<< FRAC_BITS;
		tq_full  = LW'(st_dz) <<< FRAC_BITS;
		fq       = (lift_q < top_q) ? fq_full : (fq_full >>> 1);
		tq       = (lift_q < top_q) ? tq_full : (tq_full >>> 1);
		lift_low = (lift_q < 12'(LIFT_MIN));
	end

	// division operands
	logic                 is_filt;
	logic signed [LW-1:0] tgt;
	logic signed [LW-1:0] lvl;
	logic signed [LW:0]   diff;
	logic signed [LW:0]   mix;
	logic [LW-1:0]        mag;
	logic                 neg;
	logic [13:0]          mul_b;
	logic [LW+13:0]       prod;
	logic [DW-1:0]        den;

	always_comb begin
		is_filt = (cmd.op == OP_FWD) || (cmd.op == OP_TURN);
		tgt     = (cmd.op == OP_TURN) ? tq : fq;
		lvl     = (cmd.op == OP_TURN) ? turn_q : fwd_q;
		diff    = (LW+1)'(tgt) - (LW+1)'(lvl);
		mix     = (cmd.op == OP_RIGHT) ? ((LW+1)'(fwd_q) - (LW+1)'(turn_q))
			: ((LW+1)'(fwd_q) + (LW+1)'(turn_q));
		if (is_filt) begin
			neg   = diff[LW];
			mag   = LW'(neg ? -diff : diff);
			mul_b = 14'(top_q);
			den   = DW'(top_q) + (DW'(lift_q) << LIFT_GAIN);
		end else begin
			neg   = mix[LW];
			mag   = LW'(neg ? -mix : mix);
			mul_b = 14'(MV_SCALE);
			den   = DW'(MV_DIV);
		end
		prod = (LW+14)'(mag) * (LW+14)'(mul_b);
	end

	tdcm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (NW2'(prod)),
		.den    (den),
		.quo    (quo),
		.done   (div_done)
	);

	assign status.div_done = div_done;

	// filter step and saturated millivolts
	logic signed [LW-1:0] delta;
	logic signed [LW-1:0] filt_lvl;
	logic [15:0]          mv_mag;
	logic signed [15:0]   mv;

	always_comb begin
		delta    = sign_q ? -$signed(quo[LW-1:0]) : $signed(quo[LW-1:0]);
		filt_lvl = lift_low ? tgt : (lvl + delta);
		mv_mag   = (quo > NW2'(MV_LIMIT)) ? 16'(MV_LIMIT) : quo[15:0];
		mv       = sign_q ? -$signed(mv_mag) : $signed(mv_mag);
	end

	// heading hold turn with pulsing
	logic signed [11:0]   err0;
	logic signed [11:0]   err1;
	logic signed [11:0]   err2;
	logic signed [11:0]   err3;
	logic signed [11:0]   err4;
	logic                 err_neg;
	logic [6:0]           err_mag;
	logic [4:0]           pulse_inc;
	logic                 small_err;
	logic [4:0]           pulse_next;
	logic [6:0]           turn_mag;
	logic signed [LW-1:0] turn_auto;

	always_comb begin
		err0 = $signed({3'b0, head_q}) - $signed({3'b0, face_q});
		err1 = (err0 < 0) ? (err0 + 12'sd360) : err0;
		err2 = (err1 > 12'sd180) ? (err1 - 12'sd360) : err1;
		err3 = err2 <<< 1;
		if (err3 > 12'sd127) begin
			err4 = 12'sd127;
		end else if (err3 < -12'sd127) begin
			err4 = -12'sd127;
		end else begin
			err4 = err3;
		end
		err_neg    = err4[11];
		err_mag    = 7'(err_neg ? -err4 : err4);
		pulse_inc  = pulse_q + 5'd1;
		small_err  = (err_mag < 7'(PULSE_TURN));
		pulse_next = !small_err ? pulse_q
			: ((pulse_inc > 5'(PULSE_WRAP)) ? 5'd0 : pulse_inc);
		turn_mag   = (small_err && pulse_inc > 5'(PULSE_HOLD)) ? 7'(PULSE_TURN) : err_mag;
		turn_auto  = LW'(turn_mag) << FRAC_BITS;
		if (err_neg) begin
			turn_auto = -turn_auto;
		end
	end

	// automatic forward speed
	logic signed [21:0]   dist_diff;
	logic [21:0]          dist_mag;
	logic                 near;
	logic [7:0]           spd_mag;
	logic [LW-1:0]        fw_mag;
	logic signed [LW-1:0] fwd_auto;

	always_comb begin
		dist_diff = 22'(target_q) - 22'(wheel_q);
		dist_mag  = dist_diff[21] ? 22'(-dist_diff) : 22'(dist_diff);
		near      = (mode_q == MODE_DISTANCE) && (dist_mag < 22'(NEAR_DIST));
		spd_mag   = spd_q[7] ? 8'(-spd_q) : 8'(spd_q);
		if (near) begin
			fw_mag = LW'(12'(spd_mag) * 12'(dist_mag[3:0])) << (FRAC_BITS - 4);
		end else begin
			fw_mag = LW'(spd_mag) << FRAC_BITS;
		end
		if (fw_mag != '0 && fw_mag < (LW'(FWD_MIN) << FRAC_BITS)) begin
			fw_mag = LW'(FWD_MIN) << FRAC_BITS;
		end
		fwd_auto = spd_q[7] ? -$signed(fw_mag) : $signed(fw_mag);
	end

	// configuration and mixer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_USER;
			face_q      <= '0;
			spd_q       <= '0;
			target_q    <= '0;
			top_q       <= 12'd4095;
			fwd_q       <= '0;
			turn_q      <= '0;
			pulse_q     <= '0;
			cancelled_q <= 1'b0;
		end else begin
			if (cfg_write) begin
				unique case (reg_idx_t'(cfg_index))
					REG_DRIVE_MODE: begin
						mode_q      <= cfg_data[1:0];
						cancelled_q <= 1'b0;
					end
					REG_FACE_HEADING: face_q   <= cfg_data[8:0];
					REG_AUTO_SPEED:   spd_q    <= $signed(cfg_data[7:0]);
					REG_TARGET_POS:   target_q <= $signed(cfg_data);
					REG_LIFT_TOP:     top_q    <= cfg_data[11:0];
					default: begin
					end
				endcase
			end
			if (cmd.filt_write) begin
				if (cmd.op == OP_TURN) begin
					turn_q <= filt_lvl;
				end else begin
					fwd_q <= filt_lvl;
				end
			end
			if (cmd.apply) begin
				if (mode_q != MODE_USER && !cancelled_q) begin
					fwd_q   <= fwd_auto;
					turn_q  <= turn_auto;
					pulse_q <= pulse_next;
				end
				if (cancel_q) begin
					fwd_q       <= '0;
					turn_q      <= '0;
					cancelled_q <= 1'b1;
				end
			end
		end
	end

	// request capture, division sign and result registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sf_q     <= stick_forward;
			st_q     <= stick_turn;
			lift_q   <= lift_height;
			head_q   <= heading_now;
			wheel_q  <= wheel_position;
			cancel_q <= cancel_button;
		end
		if (cmd.div_start) begin
			sign_q <= neg;
		end
		if (cmd.right_write) begin
			right_tmp_q <= mv;
		end
		if (cmd.out_load) begin
			right_mv_q <= right_tmp_q;
			left_mv_q  <= mv;
		end
	end

	assign right_millivolts = right_mv_q;
	assign left_millivolts  = left_mv_q;

endmodule

// ===== bench/tank_drive_command_mixer_tb.sv =====
module tank_drive_command_mixer_tb;
	import tdcm_pkg::*;

	typedef struct {
		logic signed [7:0]  fwd;
		logic signed [7:0]  turn;
		logic [11:0]        lift;
		logic [8:0]         head;
		logic signed [20:0] wheel;
		logic               cancel;
	} request_t;

	typedef struct {
		logic signed [15:0] right_mv;
		logic signed [15:0] left_mv;
	} volts_t;

	localparam int STALL_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [20:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [7:0] stick_forward = '0;
	logic signed [7:0] stick_turn = '0;
	logic [11:0] lift_height = '0;
	logic [8:0] heading_now = '0;
	logic signed [20:0] wheel_position = '0;
	logic cancel_button = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] right_millivolts;
	logic signed [15:0] left_millivolts;

	request_t pending_requests[$];
	volts_t expected_volts[$];
	int errors = 0;
	int idle_cycles = 0;
	bit quiet_tail = 0;
	int in_gap = 0;
	int out_gap = 0;

	// mixer state mirror
	logic [1:0] m_mode;
	logic [8:0] m_face;
	logic signed [7:0] m_speed;
	logic signed [20:0] m_target;
	logic [11:0] m_top;
	longint m_fwd, m_turn;
	int unsigned m_pulse;
	bit m_cancelled;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	tank_drive_command_mixer i_dut (.*);

	task automatic mirror_reset();
		m_mode = MODE_USER; m_face = '0; m_speed = '0; m_target = '0; m_top = 12'd4095;
		m_fwd = 0; m_turn = 0; m_pulse = 0; m_cancelled = 0;
	endtask

	function automatic longint smooth(longint level, longint goal, longint lift, longint top);
		if (lift < LIFT_MIN)
			return goal;
		return level + ((goal - level) * top) / (top + 8 * lift);
	endfunction

	function automatic logic signed [15:0] to_millivolts(longint q);
		longint mv;
		mv = (q * MV_SCALE) / MV_DIV;
		if (mv > MV_LIMIT) mv = MV_LIMIT;
		if (mv < -MV_LIMIT) mv = -MV_LIMIT;
		return mv[15:0];
	endfunction

	// predict the motor voltages for one request
	function automatic volts_t mix_request(request_t r);
		longint sf, st, one, fq, tq, tp, fw, d;
		bit neg;
		volts_t v;
		one = 1 << FRAC_BITS;
		sf = r.fwd;
		st = r.turn;
		if (sf > -DEADZONE && sf < DEADZONE) sf = 0;
		if (st > -DEADZONE && st < DEADZONE) st = 0;
		fq = sf * one;
		tq = st * one;
		if (!(r.lift < m_top)) begin
			fq = fq / 2; tq = tq / 2;
		end
		m_fwd = smooth(m_fwd, fq, r.lift, m_top);
		m_turn = smooth(m_turn, tq, r.lift, m_top);
		if (m_mode != MODE_USER && !m_cancelled) begin
			tp = longint'(r.head) - longint'(m_face);
			fw = longint'(m_speed) * one;
			neg = 0;
			if (tp < 0) tp += HEAD_WRAP;
			if (tp > HEAD_HALF) tp -= HEAD_WRAP;
			tp *= 2;
			if (tp > TURN_CLAMP) tp = TURN_CLAMP;
			if (tp < -TURN_CLAMP) tp = -TURN_CLAMP;
			if (tp < 0) begin
				tp = -tp; neg = 1;
			end
			if (tp < PULSE_TURN) begin
				m_pulse = (m_pulse + 1) & 31;
				if (m_pulse > PULSE_HOLD) tp = PULSE_TURN;
				if (m_pulse > PULSE_WRAP) m_pulse = 0;
			end
			if (neg) tp = -tp;
			if (m_mode == MODE_DISTANCE) begin
				d = longint'(m_target) - longint'(r.wheel);
				if (d < 0) d = -d;
				if (d < NEAR_DIST) fw = (fw * d) / NEAR_DIST;
			end
			if (fw > 0 && fw < FWD_MIN * one) fw = FWD_MIN * one;
			else if (fw < 0 && fw > -FWD_MIN * one) fw = -FWD_MIN * one;
			m_fwd = fw;
			m_turn = tp * one;
		end
		if (r.cancel) begin
			m_fwd = 0; m_turn = 0; m_cancelled = 1;
		end
		v.right_mv = to_millivolts(m_fwd - m_turn);
		v.left_mv = to_millivolts(m_fwd + m_turn);
		return v;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("mismatch %s: got %0d want %0d", what, got, want);
		errors++;
	endtask

	// request driver
	always @(posedge clk) begin
		request_t r;
		if (in_valid && !in_stall) begin
			expected_volts.push_back(mix_request(pending_requests.pop_front()));
		end
		if (in_valid && in_stall) begin
		end else if (in_gap > 0) begin
			in_gap <= in_gap - 1;
			in_valid <= 1'b0;
		end else if ((in_valid && !in_stall ? pending_requests.size() : pending_requests.size()) > 0
			&& arst_n) begin
			r = pending_requests[0];
			in_valid <= 1'b1;
			stick_forward <= r.fwd;
			stick_turn <= r.turn;
			lift_height <= r.lift;
			heading_now <= r.head;
			wheel_position <= r.wheel;
			cancel_button <= r.cancel;
			if (!quiet_tail && $urandom_range(0, 5) == 0) in_gap <= $urandom_range(1, 14);
		end else begin
			in_valid <= 1'b0;
		end
	end

	// result monitor and downstream stall
	always @(posedge clk) begin
		volts_t want;
		if (out_valid && !out_stall) begin
			if (expected_volts.size() == 0) begin
				report_mismatch("unexpected result", 0, 0);
			end else begin
				want = expected_volts.pop_front();
				if (right_millivolts !== want.right_mv)
					report_mismatch("right_millivolts", right_millivolts, want.right_mv);
				if (left_millivolts !== want.left_mv)
					report_mismatch("left_millivolts", left_millivolts, want.left_mv);
			end
		end
		if (out_gap > 0) begin
			out_gap <= out_gap - 1;
			out_stall <= 1'b1;
		end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
			out_gap <= $urandom_range(0, 13);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// watchdog on accepted traffic
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)
			|| (pending_requests.size() == 0 && expected_volts.size() == 0))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("tank_drive_command_mixer_tb: errors");
			$finish;
		end
	end

	function automatic request_t random_request(int lift_max);
		request_t r;
		r.fwd = 8'($urandom);
		r.turn = 8'($urandom);
		r.lift = 12'($urandom_range(0, lift_max));
		r.head = ($urandom_range(0, 9) == 0) ? 9'($urandom) : 9'($urandom_range(0, 359));
		r.wheel = 21'($urandom);
		r.cancel = ($urandom_range(0, 19) == 0);
		return r;
	endfunction

	task automatic write_register(reg_idx_t idx, logic [20:0] value);
		@(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (idx)
			REG_DRIVE_MODE: begin
				m_mode = value[1:0]; m_cancelled = 0;
			end
			REG_FACE_HEADING: m_face = value[8:0];
			REG_AUTO_SPEED: m_speed = value[7:0];
			REG_TARGET_POS: m_target = value;
			REG_LIFT_TOP: m_top = value[11:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		while (pending_requests.size() != 0 || expected_volts.size() != 0)
			@(posedge clk);
		repeat (90) @(posedge clk);
	endtask

	task automatic setup_phase(int p);
		write_register(REG_DRIVE_MODE, 21'($urandom_range(0, 3)));
		write_register(REG_FACE_HEADING, (p % 3 == 0) ? 21'd359 : 21'($urandom_range(0, 359)));
		write_register(REG_AUTO_SPEED, (p % 4 == 0) ? 21'h1FFF81 : 21'(8'($urandom)));
		write_register(REG_TARGET_POS, (p % 5 == 0) ? 21'h100000 : 21'($urandom));
		write_register(REG_LIFT_TOP, (p % 6 == 0) ? 21'd1 : 21'($urandom_range(0, 4095)));
	endtask

	initial begin
		request_t r;
		int lift_max;
		mirror_reset();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// directed: user mode extremes, deadzone edges, lift at top
		write_register(REG_LIFT_TOP, 21'd4095);
		for (int k = 0; k < 12; k++) begin
			r.fwd = (k % 4 == 0) ? -8'sd128 : (k % 4 == 1) ? 8'sd127 : (k % 4 == 2) ? 8'sd14 : -8'sd15;
			r.turn = (k % 3 == 0) ? 8'sd127 : (k % 3 == 1) ? -8'sd128 : 8'sd15;
			r.lift = (k < 4) ? 12'd0 : (k < 8) ? 12'd4095 : 12'd500;
			r.head = 9'd0; r.wheel = 21'sd0; r.cancel = (k == 11);
			pending_requests.push_back(r);
		end
		drain();
		// directed: heading hold, pulse run, wrap, mode three, distance, top zero
		write_register(REG_DRIVE_MODE, 21'd1);
		write_register(REG_FACE_HEADING, 21'd10);
		write_register(REG_AUTO_SPEED, 21'd5);
		for (int k = 0; k < 20; k++) begin
			r = random_request(499);
			r.cancel = 0;
			r.head = (k < 19) ? 9'd12 : 9'd511;
			pending_requests.push_back(r);
		end
		drain();
		write_register(REG_DRIVE_MODE, 21'd2);
		write_register(REG_TARGET_POS, 21'h0FFFFF);
		write_register(REG_AUTO_SPEED, 21'h1FFF80);
		r = random_request(4095); r.cancel = 0; r.wheel = 21'h0FFFF5;
		pending_requests.push_back(r);
		r.wheel = 21'h100000; pending_requests.push_back(r);
		r.cancel = 1; pending_requests.push_back(r);
		drain();
		write_register(REG_DRIVE_MODE, 21'd3);
		write_register(REG_LIFT_TOP, 21'd0);
		r = random_request(4095); r.lift = 12'd4095; r.cancel = 0;
		pending_requests.push_back(r);
		drain();

		// random phases, mostly small lift values with some high ones
		for (int p = 0; p < 10; p++) begin
			setup_phase(p);
			if (p == 9) quiet_tail = 1;
			for (int k = 0; k < 50; k++) begin
				lift_max = ($urandom_range(0, 2) == 0) ? 4095 : 1200;
				pending_requests.push_back(random_request(lift_max));
			end
			drain();
		end

		if (errors == 0)
			$display("tank_drive_command_mixer_tb: clean");
		else
			$display("tank_drive_command_mixer_tb: errors");
		$finish;
	end

endmodule
